// ===== hw/rtl/cio_pkg.sv =====
// Shared types and constants for the console I/O port controller.
// No dependencies; imported by the channel interfaces and the core.
package cio_pkg;

  // Where an access goes.
  typedef enum logic [3:0] {
    ROUTE_LOCAL  = 4'd0,
    ROUTE_VCNT   = 4'd1,
    ROUTE_HCNT   = 4'd2,
    ROUTE_VSTAT  = 4'd3,
    ROUTE_VDRD   = 4'd4,
    ROUTE_VDWR   = 4'd5,
    ROUTE_VCWR   = 4'd6,
    ROUTE_PSG    = 4'd7,
    ROUTE_NONE   = 4'd8
  } route_t;

  // Access kind.
  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TH_FOLLOW    = 2'd0,
    CFG_HANDHELD     = 2'd1,
    CFG_LOW_MAP      = 2'd2
  } cfg_idx_t;

  // Port address quadrants (port[7:6]).
  typedef enum logic [1:0] {
    QUAD_LOW  = 2'd0,
    QUAD_CNT  = 2'd1,
    QUAD_VDP  = 2'd2,
    QUAD_PADS = 2'd3
  } quad_t;

  localparam logic [7:0] PORT_HANDHELD  = 8'h02;
  localparam logic [7:0] PORT_PAUSE     = 8'h00;
  localparam logic [7:0] PORT_LOW_ZERO  = 8'h07;
  localparam logic [6:0] PAD_ABSENT     = 7'h7F;
  localparam logic [7:0] PAUSE_BASE     = 8'h40;
  localparam logic [7:0] BYTE_ONES      = 8'hFF;
  localparam logic [3:0] PIN_RESET      = 4'hF;

  // One input transaction.
  typedef struct packed {
    logic       mode;
    logic [7:0] port;
    logic [7:0] data;
    logic [6:0] pad_a_pins;
    logic [6:0] pad_b_pins;
    logic       pause_pressed;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] read_data;
    route_t     route;
    logic       bios_enabled;
    logic       cart_enabled;
    logic       io_disabled;
  } rsp_t;

endpackage

// ===== hw/rtl/cio_if.sv =====
// Valid/ready channel interfaces for the console I/O port controller.
// Depends on cio_pkg.

interface cio_req_if (input logic clk);
  import cio_pkg::*;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] port;
  logic [7:0] data;
  logic [6:0] pad_a_pins;
  logic [6:0] pad_b_pins;
  logic       pause_pressed;

  modport source (input clk, ready,
                  output valid, mode, port, data, pad_a_pins, pad_b_pins, pause_pressed);
  modport sink   (input clk, valid, mode, port, data, pad_a_pins, pad_b_pins, pause_pressed,
                  output ready);
endinterface

interface cio_rsp_if (input logic clk);
  import cio_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [3:0] route;
  logic       bios_enabled;
  logic       cart_enabled;
  logic       io_disabled;

  modport source (input clk, ready,
                  output valid, read_data, route, bios_enabled, cart_enabled, io_disabled);
  modport sink   (input clk, valid, read_data, route, bios_enabled, cart_enabled, io_disabled,
                  output ready);
endinterface

// ===== hw/rtl/console_io_port_controller_core.sv =====
// Console I/O port controller core: port decode, local registers, pad merge.
// Depends on cio_pkg and the channel interfaces in cio_if.sv.
//
// Each req transaction is one CPU IN or OUT access to an 8-bit port. It is
// captured in an input register, decoded by one level of logic against the
// memory-control, I/O-control and handheld registers, and the answer lands
// in a result register. One transaction per cycle sustained while rsp accepts,
// as the input register refills in the same cycle the result register loads.
// A result stalled on rsp holds a full input register, so req.ready drops.
// Accesses to video or sound ports only report the route; read_data is the
// local read byte and zero otherwise. bios/cart/io flags report their values
// after the access. Configuration (th_follow_dir, handheld_variant,
// low_port_map) is written through cfg_we/cfg_idx/cfg_wdata; the user must do
// so only while the block is idle, which the block does not enforce; writes
// to an unused index are dropped.
module console_io_port_controller_core (
  input  logic                             clk,
  input  logic                             rst,
  cio_req_if.sink                          req,
  cio_rsp_if.source                        rsp,
  input  logic                             cfg_we,
  input  logic [cio_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic                             cfg_wdata
);
  import cio_pkg::*;

  // Configuration
  logic th_follow_dir, handheld_variant, low_port_map;

  // Block state
  logic [3:0] pin_direction, pin_level;
  logic [7:0] handheld_reg;
  logic       bios_on, cart_on, io_off;

  // Input register
  logic s1_valid;
  req_t s1;

  // Result register
  logic out_valid;
  rsp_t out;

  logic out_load, s1_adv;

  assign out_load  = s1_valid && (!out_valid || rsp.ready);
  assign s1_adv    = out_load;
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      th_follow_dir    <= 1'b0;
      handheld_variant <= 1'b0;
      low_port_map     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TH_FOLLOW:    th_follow_dir    <= cfg_wdata;
        CFG_HANDHELD:     handheld_variant <= cfg_wdata;
        CFG_LOW_MAP:      low_port_map     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- decode of the registered access ----
  logic [6:0] pb;
  logic [7:0] p1, p2, low_rd, rd;
  logic       odd;
  quad_t      quad;
  route_t     route;

  logic [3:0] pin_direction_next, pin_level_next;
  logic [7:0] handheld_reg_next;
  logic       bios_on_next, cart_on_next, io_off_next;

  assign pb   = handheld_variant ? PAD_ABSENT : s1.pad_b_pins;
  assign odd  = s1.port[0];
  assign quad = quad_t'(s1.port[7:6]);

  // Port 1 view: pad A pins 0-5, pad B up/down on top; A.TR from level if output.
  always_comb begin
    p1 = {pb[1:0], s1.pad_a_pins[5:0]};
    if (!pin_direction[0]) p1[5] = pin_level[0];
  end

  // Port 2 view: pad B left..TR, two fixed ones, A.TH, B.TH.
  always_comb begin
    p2 = {pb[6], s1.pad_a_pins[6], 2'b11, pb[5:2]};
    if (!pin_direction[2]) p2[3] = pin_level[2];
    if (!pin_direction[1]) p2[6] = pin_level[1];
    if (!pin_direction[3]) p2[7] = pin_level[3];
  end

  // Low port reads: open bus, or the handheld map.
  always_comb begin
    priority if (!low_port_map)               low_rd = s1.data;
    else if (s1.port == PORT_PAUSE)
      low_rd = PAUSE_BASE | {(handheld_variant && s1.pause_pressed), 7'd0};
    else if (s1.port == PORT_HANDHELD)        low_rd = handheld_reg;
    else if (s1.port <= PORT_LOW_ZERO)        low_rd = 8'd0;
    else                                      low_rd = BYTE_ONES;
  end

  always_comb begin
    rd                 = 8'd0;
    route              = ROUTE_NONE;
    pin_direction_next = pin_direction;
    pin_level_next     = pin_level;
    handheld_reg_next  = handheld_reg;
    bios_on_next       = bios_on;
    cart_on_next       = cart_on;
    io_off_next        = io_off;
    if (mode_t'(s1.mode) == MODE_READ) begin
      unique case (quad)
        QUAD_LOW: begin
          route = ROUTE_LOCAL;
          rd    = low_rd;
        end
        QUAD_CNT:  route = odd ? ROUTE_HCNT : ROUTE_VCNT;
        QUAD_VDP:  route = odd ? ROUTE_VSTAT : ROUTE_VDRD;
        QUAD_PADS: begin
          route = ROUTE_LOCAL;
          rd    = odd ? p2 : p1;
        end
        default: ;
      endcase
    end else begin
      priority if (s1.port == PORT_HANDHELD) begin
        route             = ROUTE_LOCAL;
        handheld_reg_next = s1.data;
      end else if (quad == QUAD_LOW) begin
        route = ROUTE_LOCAL;
        if (odd) begin
          // I/O control: direction in low nibble; TH level may follow TH dir
          pin_direction_next = s1.data[3:0];
          pin_level_next = th_follow_dir
                         ? {s1.data[3], pin_level[2], s1.data[1], pin_level[0]}
                         : s1.data[7:4];
        end else begin
          // memory control; handheld ignores BIOS/cart bits
          if (!handheld_variant) begin
            bios_on_next = !s1.data[3];
            cart_on_next = !s1.data[6];
          end
          io_off_next = s1.data[2];
        end
      end else if (quad == QUAD_CNT) begin
        route = ROUTE_PSG;
      end else if (quad == QUAD_VDP) begin
        route = odd ? ROUTE_VCWR : ROUTE_VDWR;
      end else begin
        route = ROUTE_NONE;
      end
    end
  end

  // ---- pipeline and state registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      pin_direction <= PIN_RESET;
      pin_level     <= PIN_RESET;
      handheld_reg  <= 8'd0;
      bios_on       <= 1'b1;
      cart_on       <= 1'b1;
      io_off        <= 1'b0;
    end else begin
      if (req.ready) s1_valid <= req.valid;
      if (out_load) begin
        out_valid     <= 1'b1;
        pin_direction <= pin_direction_next;
        pin_level     <= pin_level_next;
        handheld_reg  <= handheld_reg_next;
        bios_on       <= bios_on_next;
        cart_on       <= cart_on_next;
        io_off        <= io_off_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1.mode          <= req.mode;
      s1.port          <= req.port;
      s1.data          <= req.data;
      s1.pad_a_pins    <= req.pad_a_pins;
      s1.pad_b_pins    <= req.pad_b_pins;
      s1.pause_pressed <= req.pause_pressed;
    end
    if (out_load) begin
      out.read_data    <= rd;
      out.route        <= route;
      out.bios_enabled <= bios_on_next;
      out.cart_enabled <= cart_on_next;
      out.io_disabled  <= io_off_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out.read_data;
  assign rsp.route        = out.route;
  assign rsp.bios_enabled = out.bios_enabled;
  assign rsp.cart_enabled = out.cart_enabled;
  assign rsp.io_disabled  = out.io_disabled;

endmodule
